// ===== rtl/sia_pkg.sv =====
// shared constants and types for the signed integer alu
`default_nettype none
package sia_pkg;

   localparam int DEFAULT_WORD_BITS = 128;
   localparam int OUT_WORD_BITS     = 128;
   localparam int LIMB_BITS         = 32;
   localparam int OP_BITS           = 4;
   localparam int SHIFT_BITS        = 7;
   localparam int HALF_BITS         = 64;
   localparam int REQ_DATA_BITS     = 272;
   localparam int RSP_DATA_BITS     = 136;
   localparam int RECIP_FRAC_BITS   = 16;

   localparam logic [OP_BITS-1:0] OP_ADD = 4'd0;
   localparam logic [OP_BITS-1:0] OP_SUB = 4'd1;
   localparam logic [OP_BITS-1:0] OP_MUL = 4'd2;
   localparam logic [OP_BITS-1:0] OP_DIV = 4'd3;
   localparam logic [OP_BITS-1:0] OP_AND = 4'd4;
   localparam logic [OP_BITS-1:0] OP_OR  = 4'd5;
   localparam logic [OP_BITS-1:0] OP_XOR = 4'd6;
   localparam logic [OP_BITS-1:0] OP_NOT = 4'd7;
   localparam logic [OP_BITS-1:0] OP_NEG = 4'd8;
   localparam logic [OP_BITS-1:0] OP_SHL = 4'd9;
   localparam logic [OP_BITS-1:0] OP_SAR = 4'd10;
   localparam logic [OP_BITS-1:0] OP_ROL = 4'd11;
   localparam logic [OP_BITS-1:0] OP_ROR = 4'd12;
   localparam logic [OP_BITS-1:0] OP_CMP = 4'd13;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic               less;
      logic               eq;
      logic               dz;
      logic               negq;
   } side_flags_type;

endpackage
`default_nettype wire

// ===== rtl/sia_mul.sv =====
// three stage low-half multiplier built from 32 by 32 partial products
`default_nettype none
module sia_mul import sia_pkg::*; #(
   parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic [WORD_BITS-1:0] a,
   input  wire logic [WORD_BITS-1:0] b,
   output logic      [WORD_BITS-1:0] prod
);
   localparam int L  = (WORD_BITS + LIMB_BITS - 1) / LIMB_BITS;
   localparam int PW = L * LIMB_BITS;
   localparam int XW = PW + 2 * LIMB_BITS;

   logic [PW-1:0]          a_pad, b_pad;
   logic [2*LIMB_BITS-1:0] pp_in [L*L];
   logic [2*LIMB_BITS-1:0] pp_ff [L*L];
   logic [WORD_BITS-1:0]   row_in [L];
   logic [WORD_BITS-1:0]   row_ff [L];
   logic [WORD_BITS-1:0]   prod_in, prod_ff;

   assign a_pad = PW'(a);
   assign b_pad = PW'(b);

   always_comb begin
      for (int i = 0; i < L; i++) begin
         for (int j = 0; j < L; j++) begin
            if (i + j < L) begin
               pp_in[i*L+j] = a_pad[i*LIMB_BITS +: LIMB_BITS] * b_pad[j*LIMB_BITS +: LIMB_BITS];
            end else begin
               pp_in[i*L+j] = '0;
            end
         end
      end
   end

   always_comb begin
      logic [XW-1:0] tmp;
      for (int i = 0; i < L; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < L; j++) begin
            tmp = XW'(pp_ff[i*L+j]) << (LIMB_BITS * (i + j));
            row_in[i] = row_in[i] + tmp[WORD_BITS-1:0];
         end
      end
   end

   always_comb begin
      prod_in = '0;
      for (int i = 0; i < L; i++) begin
         prod_in = prod_in + row_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff   <= pp_in;
         row_ff  <= row_in;
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

// ===== rtl/sia_div.sv =====
// restoring divider, one quotient bit per pipeline stage, side data carried along
`default_nettype none
module sia_div import sia_pkg::*; #(
   parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire logic [WORD_BITS-1:0] in_num,
   input  wire logic [WORD_BITS-1:0] in_den,
   input  wire logic [WORD_BITS-1:0] in_alt,
   input  wire side_flags_type       in_flags,
   output logic                      out_valid,
   output logic      [WORD_BITS-1:0] out_quot,
   output logic      [WORD_BITS-1:0] out_alt,
   output side_flags_type            out_flags
);
   localparam int S = WORD_BITS;

   logic [WORD_BITS-1:0] rem_in [S], rem_ff [S];
   logic [WORD_BITS-1:0] num_in [S], num_ff [S];
   logic [WORD_BITS-1:0] den_ff [S];
   logic [WORD_BITS-1:0] alt_ff [S];
   side_flags_type       flags_ff [S];
   logic [S-1:0]         valid_ff;

   always_comb begin
      logic [WORD_BITS-1:0] prem, pnum, pden, rn;
      for (int k = 0; k < S; k++) begin
         prem = (k == 0) ? '0 : rem_ff[(k == 0) ? 0 : k-1];
         pnum = (k == 0) ? in_num : num_ff[(k == 0) ? 0 : k-1];
         pden = (k == 0) ? in_den : den_ff[(k == 0) ? 0 : k-1];
         rn = {prem[WORD_BITS-2:0], pnum[WORD_BITS-1]};
         if (rn >= pden) begin
            rem_in[k] = rn - pden;
            num_in[k] = {pnum[WORD_BITS-2:0], 1'b1};
         end else begin
            rem_in[k] = rn;
            num_in[k] = {pnum[WORD_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < S; k++) begin
            rem_ff[k] <= rem_in[k];
            num_ff[k] <= num_in[k];
            if (k == 0) begin
               den_ff[k]   <= in_den;
               alt_ff[k]   <= in_alt;
               flags_ff[k] <= in_flags;
            end else begin
               den_ff[k]   <= den_ff[k-1];
               alt_ff[k]   <= alt_ff[k-1];
               flags_ff[k] <= flags_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[S-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[S-1];
   assign out_quot  = num_ff[S-1];
   assign out_alt   = alt_ff[S-1];
   assign out_flags = flags_ff[S-1];

endmodule
`default_nettype wire

// ===== rtl/signed_int128_alu.sv =====
// top level of the pipelined signed integer alu
// requests arrive on req_ (tvalid/tready/tdata) and results leave on rsp_.
// each request carries an operation, two operands in 64-bit halves and a
// shift count; each yields exactly one response holding the result,
// sign-extended to 128 bits, and the less, equal and divide-by-zero flags.
// only the low WORD_BITS bits of each operand count.
// requests pass through one input register, three multiplier stages, one
// divider stage per quotient bit and one output register. a new request is
// taken every cycle while the pipeline is not held.
// the whole pipeline advances together; when the receiver holds off
// rsp_tready with a response waiting, every stage holds and req_tready
// drops, so nothing is lost or repeated.
// synchronous reset clears all valid bits; the block is ready at once.
`default_nettype none
module signed_int128_alu import sia_pkg::*; #(
   parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // operation, operand_a_low, operand_a_high, operand_b_low, operand_b_high,
   // shift_amount, zero fill
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // result_low, result_high, is_less, is_equal, divide_by_zero, zero fill
   output logic      [RSP_DATA_BITS-1:0] rsp_tdata
);
   localparam int SW    = $clog2(WORD_BITS) + 1;
   localparam int RECIP = ((1 << RECIP_FRAC_BITS) + WORD_BITS - 1) / WORD_BITS;
   localparam int RW    = RECIP_FRAC_BITS + 1;
   localparam int DLY   = 3;

   logic en;

   // input register
   logic                  v0_ff;
   logic [OP_BITS-1:0]    op0_ff;
   logic [WORD_BITS-1:0]  a0_ff, b0_ff;
   logic [SHIFT_BITS-1:0] s0_ff;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op0_ff <= req_tdata[OP_BITS-1:0];
         a0_ff  <= WORD_BITS'(req_tdata[OP_BITS +: 2*HALF_BITS]);
         b0_ff  <= WORD_BITS'(req_tdata[OP_BITS+2*HALF_BITS +: 2*HALF_BITS]);
         s0_ff  <= req_tdata[OP_BITS+4*HALF_BITS +: SHIFT_BITS];
      end
   end

   // simple operations, flags and divider operand preparation
   logic [WORD_BITS-1:0]  alt_in, maga_in, magb_in;
   side_flags_type        flags_in;
   logic [RW+SHIFT_BITS-1:0] rq_prod;
   logic [SHIFT_BITS-1:0] rq;
   logic [SW-1:0]         rot, rot_inv;

   always_comb begin
      rq_prod = (RW+SHIFT_BITS)'(s0_ff) * (RW+SHIFT_BITS)'(RECIP);
      rq      = SHIFT_BITS'(rq_prod >> RECIP_FRAC_BITS);
      rot     = SW'(s0_ff) - SW'(SW'(rq) * SW'(WORD_BITS));
      rot_inv = SW'(WORD_BITS) - rot;
   end

   always_comb begin
      alt_in        = '0;
      flags_in      = '0;
      flags_in.op   = op0_ff;
      maga_in       = a0_ff[WORD_BITS-1] ? -a0_ff : a0_ff;
      magb_in       = b0_ff[WORD_BITS-1] ? -b0_ff : b0_ff;
      case (op0_ff)
         OP_ADD: alt_in = a0_ff + b0_ff;
         OP_SUB: alt_in = a0_ff - b0_ff;
         OP_DIV: begin
            flags_in.dz   = (b0_ff == '0);
            flags_in.negq = a0_ff[WORD_BITS-1] ^ b0_ff[WORD_BITS-1];
         end
         OP_AND: alt_in = a0_ff & b0_ff;
         OP_OR:  alt_in = a0_ff | b0_ff;
         OP_XOR: alt_in = a0_ff ^ b0_ff;
         OP_NOT: alt_in = ~a0_ff;
         OP_NEG: alt_in = -a0_ff;
         OP_SHL: alt_in = a0_ff << s0_ff;
         OP_SAR: alt_in = WORD_BITS'($signed(a0_ff) >>> s0_ff);
         OP_ROL: alt_in = (a0_ff << rot) | (a0_ff >> rot_inv);
         OP_ROR: alt_in = (a0_ff >> rot) | (a0_ff << rot_inv);
         OP_CMP: begin
            flags_in.less = $signed(a0_ff) < $signed(b0_ff);
            flags_in.eq   = (a0_ff == b0_ff);
         end
         default: alt_in = '0;
      endcase
   end

   // multiplier and the matching delay for everything else
   logic [WORD_BITS-1:0] prod;
   logic [DLY-1:0]       vd_ff;
   logic [WORD_BITS-1:0] altd_ff [DLY], magad_ff [DLY], magbd_ff [DLY];
   side_flags_type       flagsd_ff [DLY];
   logic [WORD_BITS-1:0] div_alt;

   sia_mul #(.WORD_BITS(WORD_BITS)) u_mul (
      .clock (clock),
      .en    (en),
      .a     (a0_ff),
      .b     (b0_ff),
      .prod  (prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= '0;
      end else if (en) begin
         vd_ff <= {vd_ff[DLY-2:0], v0_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         altd_ff[0]   <= alt_in;
         magad_ff[0]  <= maga_in;
         magbd_ff[0]  <= magb_in;
         flagsd_ff[0] <= flags_in;
         for (int k = 1; k < DLY; k++) begin
            altd_ff[k]   <= altd_ff[k-1];
            magad_ff[k]  <= magad_ff[k-1];
            magbd_ff[k]  <= magbd_ff[k-1];
            flagsd_ff[k] <= flagsd_ff[k-1];
         end
      end
   end

   assign div_alt = (flagsd_ff[DLY-1].op == OP_MUL) ? prod : altd_ff[DLY-1];

   // divider
   logic                 dv_valid;
   logic [WORD_BITS-1:0] dv_quot, dv_alt;
   side_flags_type       dv_flags;

   sia_div #(.WORD_BITS(WORD_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vd_ff[DLY-1]),
      .in_num    (magad_ff[DLY-1]),
      .in_den    (magbd_ff[DLY-1]),
      .in_alt    (div_alt),
      .in_flags  (flagsd_ff[DLY-1]),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_alt   (dv_alt),
      .out_flags (dv_flags)
   );

   // output register
   logic [WORD_BITS-1:0]     res;
   logic                     out_v_ff;
   logic [RSP_DATA_BITS-1:0] out_data_ff, out_data_in;

   always_comb begin
      if (dv_flags.op == OP_DIV) begin
         if (dv_flags.dz) begin
            res = '0;
         end else if (dv_flags.negq) begin
            res = -dv_quot;
         end else begin
            res = dv_quot;
         end
      end else begin
         res = dv_alt;
      end
      out_data_in = {5'b0, dv_flags.dz, dv_flags.eq, dv_flags.less,
                     OUT_WORD_BITS'($signed(res))};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;

   // checks
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[130] |-> rsp_tdata[127:0] == '0)
      else $error("divide by zero with non-zero result");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tdata[130:128]))
      else $error("more than one flag set");

   a_cmp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[128] || rsp_tdata[129]) |-> rsp_tdata[127:0] == '0)
      else $error("compare with non-zero result");

endmodule
`default_nettype wire
